[sv/sbda_pkg.sv]
package sbda_pkg;

  localparam int VALUE_WIDTH = 32;
  // decimal digits needed for a VALUE_WIDTH-bit magnitude (1233/4096 ~ log10 2)
  localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_WIDTH = DIGITS * 4;
  localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_WIDTH = $clog2(DIGITS + 1);

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_MINUS = 7'h2d;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit_shift;
  } dab_ctrl_t;

  // add-3 correction of one BCD digit before the shift
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

[sv/sbda_dabble.sv]
module sbda_dabble (
  input  logic                           clk,
  input  sbda_pkg::dab_ctrl_t            ctrl,
  input  logic [sbda_pkg::VALUE_WIDTH-1:0] magnitude,
  output logic [3:0]                     top_digit
);
  import sbda_pkg::*;

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_WIDTH-1:0]   bcd;
  logic [BCD_WIDTH-1:0]   bcd_adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = bcd_adjust(bcd[i*4 +: 4]);
    end
  end

  // shift-add-3: one magnitude bit per cycle, then one digit per cycle out the top
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= magnitude;
      bcd <= '0;
    end else if (ctrl.conv) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_WIDTH-2:0], mag[VALUE_WIDTH-1]};
    end else if (ctrl.emit_shift) begin
      bcd <= {bcd[BCD_WIDTH-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[BCD_WIDTH-1 -: 4];

endmodule

[sv/signed_binary_to_decimal_ascii.sv]
// One number occupies the block until its last character is out:
// one magnitude bit a cycle through the BCD shifter, then the minus sign if
// negative, then one digit a cycle, leading zeros skipped without a strobe.
// Characters appear one per strobe cycle; the receiver cannot stall.
// Synchronous active-high reset returns the block to idle, no strobe.
module signed_binary_to_decimal_ascii (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sbda_pkg::VALUE_WIDTH-1:0] value,
  output logic                                  strobe,
  output logic [6:0]                            character,
  output logic                                  last
);
  import sbda_pkg::*;

  state_t                   state, state_next;
  logic [BIT_CNT_WIDTH-1:0] bit_cnt, bit_cnt_next;
  logic [DIG_CNT_WIDTH-1:0] dig_cnt, dig_cnt_next;
  logic                     neg, neg_next;
  logic                     seen, seen_next;

  logic [VALUE_WIDTH-1:0]   value_u;
  logic [VALUE_WIDTH-1:0]   magnitude;
  logic [3:0]               top_digit;
  logic                     emit_now;
  dab_ctrl_t                ctrl;

  assign value_u   = value;
  assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

  sbda_dabble u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .magnitude (magnitude),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      dig_cnt <= '0;
      neg     <= 1'b0;
      seen    <= 1'b0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      dig_cnt <= dig_cnt_next;
      neg     <= neg_next;
      seen    <= seen_next;
    end
  end

  assign emit_now = seen || (top_digit != 4'd0) || (dig_cnt == DIG_CNT_WIDTH'(1));

  always_comb begin
    state_next      = state;
    bit_cnt_next    = bit_cnt;
    dig_cnt_next    = dig_cnt;
    neg_next        = neg;
    seen_next       = seen;
    ctrl            = '0;
    busy            = 1'b1;
    strobe          = 1'b0;
    last            = 1'b0;
    character       = ASCII_ZERO | {3'd0, top_digit};
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load    = 1'b1;
          neg_next     = value_u[VALUE_WIDTH-1];
          bit_cnt_next = BIT_CNT_WIDTH'(VALUE_WIDTH);
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv    = 1'b1;
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_WIDTH'(1)) begin
          dig_cnt_next = DIG_CNT_WIDTH'(DIGITS);
          seen_next    = 1'b0;
          state_next   = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        strobe     = 1'b1;
        character  = ASCII_MINUS;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctrl.emit_shift = 1'b1;
        strobe          = emit_now;
        last            = emit_now && (dig_cnt == DIG_CNT_WIDTH'(1));
        dig_cnt_next    = dig_cnt - 1'b1;
        seen_next       = seen || emit_now;
        if (dig_cnt == DIG_CNT_WIDTH'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/sbda_check.sv]
module sbda_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  strobe,
  input logic [6:0]                            character,
  input logic                                  last
);
  import sbda_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("character beat while idle");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without a character beat");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("still busy after final character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted number did not raise busy");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && character == ASCII_MINUS) |-> !last)
    else $error("minus sign flagged as final character");

endmodule

bind signed_binary_to_decimal_ascii sbda_check u_sbda_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);
